// ----- sv/kcf_pkg.sv -----
// Shared types and constants for the keypad calculator core.
// Holds key codes, the controller/datapath command and status structs, and enums.
// No dependencies.
`default_nettype none

package kcf_pkg;

   localparam int unsigned KEY_WIDTH    = 8;
   localparam int unsigned RESULT_WIDTH = 16;

   localparam logic [KEY_WIDTH-1:0] KEY_DIGIT_MAX = 8'd9;
   localparam logic [KEY_WIDTH-1:0] KEY_CLEAR     = 8'h7E; // '~'
   localparam logic [KEY_WIDTH-1:0] KEY_EQUALS    = 8'h3D; // '='
   localparam logic [KEY_WIDTH-1:0] KEY_PLUS      = 8'h2B; // '+'
   localparam logic [KEY_WIDTH-1:0] KEY_MINUS     = 8'h2D; // '-'
   localparam logic [KEY_WIDTH-1:0] KEY_TIMES     = 8'h2A; // '*'
   localparam logic [KEY_WIDTH-1:0] KEY_DIVIDE    = 8'h2F; // '/'

   localparam logic [3:0] DECIMAL_BASE = 4'd10;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CALC,
      ST_WRITE
   } state_type;

   typedef enum logic [2:0] {
      OPC_OTHER,
      OPC_ADD,
      OPC_SUB,
      OPC_MUL,
      OPC_DIV
   } opclass_type;

   typedef struct packed {
      logic clear;
      logic acc_n1;
      logic acc_n2;
      logic load_op;
      logic div_start;
      logic div_step;
      logic calc_load;
      logic write_rsp;
   } cmd_type;

   typedef struct packed {
      logic        key_digit;
      logic        key_equals;
      logic        key_clear;
      opclass_type op_class;
      logic        div_last;
      logic        out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- sv/kcf_ctrl.sv -----
// Controller state machine of the keypad calculator core.
// Tracks the entry phase and sequences accumulate, divide, result and output steps.
// Depends on kcf_pkg.
`default_nettype none

module kcf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kcf_pkg::sts_type sts,
   output kcf_pkg::cmd_type      cmd
);

   kcf_pkg::state_type state_ff, state_in;
   kcf_pkg::phase_type phase_ff, phase_in;
   logic               accept;

   assign req_stall = (state_ff != kcf_pkg::ST_IDLE);
   assign accept    = req_valid && (state_ff == kcf_pkg::ST_IDLE);

   // next state and phase
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         kcf_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (sts.key_clear) begin
                  phase_in = kcf_pkg::PH_FIRST;
               end else if (phase_ff == kcf_pkg::PH_FIRST) begin
                  if (!sts.key_digit && !sts.key_equals) begin
                     phase_in = kcf_pkg::PH_SECOND;
                  end
               end else if (phase_ff == kcf_pkg::PH_SECOND) begin
                  if (sts.key_equals) begin
                     phase_in = kcf_pkg::PH_DONE;
                     state_in = (sts.op_class == kcf_pkg::OPC_DIV) ?
                                kcf_pkg::ST_DIV : kcf_pkg::ST_CALC;
                  end
               end else begin
                  phase_in = phase_ff;
               end
            end
         end
         kcf_pkg::ST_DIV: begin
            if (sts.div_last) begin
               state_in = kcf_pkg::ST_CALC;
            end
         end
         kcf_pkg::ST_CALC: begin
            state_in = kcf_pkg::ST_WRITE;
         end
         kcf_pkg::ST_WRITE: begin
            if (sts.out_free) begin
               state_in = kcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kcf_pkg::ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         kcf_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (sts.key_clear) begin
                  cmd.clear = 1'b1;
               end else if (phase_ff == kcf_pkg::PH_FIRST) begin
                  cmd.acc_n1  = sts.key_digit;
                  cmd.load_op = !sts.key_digit && !sts.key_equals;
               end else if (phase_ff == kcf_pkg::PH_SECOND) begin
                  cmd.acc_n2    = sts.key_digit;
                  cmd.div_start = sts.key_equals && (sts.op_class == kcf_pkg::OPC_DIV);
               end else begin
                  cmd.clear = 1'b0;
               end
            end
         end
         kcf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         kcf_pkg::ST_CALC: begin
            cmd.calc_load = 1'b1;
         end
         kcf_pkg::ST_WRITE: begin
            cmd.write_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcf_pkg::ST_IDLE;
         phase_ff <= kcf_pkg::PH_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/kcf_dpath.sv -----
// Datapath of the keypad calculator core: operand accumulators, operator,
// restoring divider, result register and the result output register.
// Depends on kcf_pkg.
`default_nettype none

module kcf_dpath #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [kcf_pkg::KEY_WIDTH-1:0]        req_key_code,
   input  wire kcf_pkg::cmd_type                     cmd,
   output kcf_pkg::sts_type                          sts,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_result_negative,
   output logic [kcf_pkg::RESULT_WIDTH-1:0]          rsp_result_magnitude,
   output logic                                      rsp_divide_by_zero
);

   localparam int unsigned W  = VALUE_WIDTH;
   localparam int unsigned CW = $clog2(VALUE_WIDTH);
   localparam int unsigned MW = (VALUE_WIDTH > kcf_pkg::RESULT_WIDTH) ?
                                VALUE_WIDTH : kcf_pkg::RESULT_WIDTH;

   logic [W-1:0]            n1_ff, n1_in;
   logic [W-1:0]            n2_ff, n2_in;
   kcf_pkg::opclass_type    op_ff, op_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic [W-1:0]            quo_ff, quo_in;
   logic [W-1:0]            dvs_ff, dvs_in;
   logic                    qneg_ff, qneg_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [W-1:0]            res_ff, res_in;
   logic                    dz_ff, dz_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_neg_ff, rsp_neg_in;
   logic [kcf_pkg::RESULT_WIDTH-1:0] rsp_mag_ff, rsp_mag_in;
   logic                    rsp_dz_ff, rsp_dz_in;

   logic [kcf_pkg::KEY_WIDTH-1:0] key;
   logic [W-1:0]            digit;
   logic [W-1:0]            acc_src, acc_val;
   kcf_pkg::opclass_type    key_class;
   logic [W:0]              shifted, diff;
   logic                    fits;
   logic [2*W-1:0]          product;
   logic                    n2_zero;
   logic [W-1:0]            quo_signed;
   logic [W-1:0]            mag;
   logic [MW-1:0]           mag_ext;

   assign key     = req_key_code;
   assign digit   = W'(key[3:0]);
   assign n2_zero = (n2_ff == '0);

   // operator key to operation class
   always_comb begin
      unique case (key)
         kcf_pkg::KEY_PLUS:   key_class = kcf_pkg::OPC_ADD;
         kcf_pkg::KEY_MINUS:  key_class = kcf_pkg::OPC_SUB;
         kcf_pkg::KEY_TIMES:  key_class = kcf_pkg::OPC_MUL;
         kcf_pkg::KEY_DIVIDE: key_class = kcf_pkg::OPC_DIV;
         default:             key_class = kcf_pkg::OPC_OTHER;
      endcase
   end

   // times ten plus digit, by shift and add
   assign acc_src = cmd.acc_n2 ? n2_ff : n1_ff;
   assign acc_val = (acc_src << 3) + (acc_src << 1) + digit;

   // one restoring division step
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits    = (shifted >= {1'b0, dvs_ff});
   assign diff    = shifted - {1'b0, dvs_ff};

   assign product    = n1_ff * n2_ff;
   assign quo_signed = qneg_ff ? (W'(0) - quo_ff) : quo_ff;

   always_comb begin
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      dz_in   = dz_ff;
      if (cmd.clear) begin
         n1_in = '0;
         n2_in = '0;
         op_in = kcf_pkg::OPC_OTHER;
      end
      if (cmd.acc_n1) begin
         n1_in = acc_val;
      end
      if (cmd.acc_n2) begin
         n2_in = acc_val;
      end
      if (cmd.load_op) begin
         op_in = key_class;
      end
      if (cmd.div_start) begin
         rem_in  = '0;
         quo_in  = n1_ff[W-1] ? (W'(0) - n1_ff) : n1_ff;
         dvs_in  = n2_ff[W-1] ? (W'(0) - n2_ff) : n2_ff;
         qneg_in = n1_ff[W-1] ^ n2_ff[W-1];
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.calc_load) begin
         dz_in = 1'b0;
         unique case (op_ff)
            kcf_pkg::OPC_ADD: res_in = n1_ff + n2_ff;
            kcf_pkg::OPC_SUB: res_in = n1_ff - n2_ff;
            kcf_pkg::OPC_MUL: res_in = product[W-1:0];
            kcf_pkg::OPC_DIV: begin
               dz_in  = n2_zero;
               res_in = n2_zero ? '0 : quo_signed;
            end
            default:          res_in = n2_ff;
         endcase
      end
   end

   // result to sign and magnitude, held until taken
   assign mag     = res_ff[W-1] ? (W'(0) - res_ff) : res_ff;
   assign mag_ext = MW'(mag);

   always_comb begin
      rsp_neg_in   = rsp_neg_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_rsp) begin
         rsp_neg_in   = res_ff[W-1];
         rsp_mag_in   = mag_ext[kcf_pkg::RESULT_WIDTH-1:0];
         rsp_dz_in    = dz_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_ff        <= '0;
         n2_ff        <= '0;
         op_ff        <= kcf_pkg::OPC_OTHER;
         rsp_valid_ff <= 1'b0;
      end else begin
         n1_ff        <= n1_in;
         n2_ff        <= n2_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      qneg_ff    <= qneg_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      dz_ff      <= dz_in;
      rsp_neg_ff <= rsp_neg_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_dz_ff  <= rsp_dz_in;
   end

   assign sts.key_digit  = (key <= kcf_pkg::KEY_DIGIT_MAX);
   assign sts.key_equals = (key == kcf_pkg::KEY_EQUALS);
   assign sts.key_clear  = (key == kcf_pkg::KEY_CLEAR);
   assign sts.op_class   = op_ff;
   assign sts.div_last   = (cnt_ff == CW'(VALUE_WIDTH - 1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_negative  = rsp_neg_ff;
   assign rsp_result_magnitude = rsp_mag_ff;
   assign rsp_divide_by_zero   = rsp_dz_ff;

endmodule

`default_nettype wire

// ----- sv/keypad_calculator_fsm_core.sv -----
// Keypad four-function calculator. Each request carries one key code: 0..9 are
// digits, '+', '-', '*', '/' pick the operator, '=' computes and '~' clears. Operands
// and results wrap modulo 2^VALUE_WIDTH as two's complement; one response (sign,
// magnitude, divide-by-zero flag) follows each '=' in second-operand entry, and
// later keys are dropped until '~'. Digit, operator and clear keys are taken while the
// core is idle. After '=' the result is computed and then written out; for '/' the
// one-bit-per-cycle restoring divider runs first. New keys are stalled until the result
// is written. A finished response sits in an output register, so the next key is taken while it waits.
// Depends on kcf_pkg, kcf_ctrl and kcf_dpath.
`default_nettype none

module keypad_calculator_fsm_core #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [kcf_pkg::KEY_WIDTH-1:0]       req_key_code,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_result_negative,
   output logic [kcf_pkg::RESULT_WIDTH-1:0]         rsp_result_magnitude,
   output logic                                     rsp_divide_by_zero
);

   kcf_pkg::cmd_type cmd;
   kcf_pkg::sts_type sts;

   kcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kcf_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .req_key_code         (req_key_code),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_negative  (rsp_result_negative),
      .rsp_result_magnitude (rsp_result_magnitude),
      .rsp_divide_by_zero   (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire

// ----- test/keypad_calc_checker.sv -----
// Checker for the keypad calculator core: watches the request and response channels,
// predicts each response from the accepted keys and compares field by field.
// Depends on kcf_pkg.
`default_nettype none

module keypad_calc_checker #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [kcf_pkg::KEY_WIDTH-1:0]    req_key_code,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_result_negative,
   input  wire logic [kcf_pkg::RESULT_WIDTH-1:0] rsp_result_magnitude,
   input  wire logic                             rsp_divide_by_zero,
   output int unsigned                           pending_results,
   output int unsigned                           mismatch_count
);

   localparam int unsigned KEY_WIDTH    = kcf_pkg::KEY_WIDTH;
   localparam int unsigned RESULT_WIDTH = kcf_pkg::RESULT_WIDTH;

   typedef struct packed {
      logic                    negative;
      logic [RESULT_WIDTH-1:0] magnitude;
      logic                    div_zero;
   } calc_answer_type;

   kcf_pkg::phase_type     calc_phase;
   logic [VALUE_WIDTH-1:0] lhs_value;
   logic [VALUE_WIDTH-1:0] rhs_value;
   logic [KEY_WIDTH-1:0]   op_key;
   calc_answer_type        expected_answers[$];

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("checker: %s mismatch, got %0d, want %0d", what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_calc();
      calc_phase = kcf_pkg::PH_FIRST;
      lhs_value  = '0;
      rhs_value  = '0;
      op_key     = '0;
   endtask

   // Advance the calculator by one key; queue the answer that an equals key produces.
   task automatic press_key(input logic [KEY_WIDTH-1:0] key);
      logic [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0] magnitude;
      longint                 dividend;
      longint                 divisor;
      longint                 quotient;
      calc_answer_type        answer;
      if (key == kcf_pkg::KEY_CLEAR) begin
         clear_calc();
      end else if (calc_phase == kcf_pkg::PH_FIRST) begin
         if (key <= kcf_pkg::KEY_DIGIT_MAX) begin
            lhs_value = lhs_value * VALUE_WIDTH'(10) + VALUE_WIDTH'(key);
         end else if (key != kcf_pkg::KEY_EQUALS) begin
            op_key     = key;
            calc_phase = kcf_pkg::PH_SECOND;
         end
      end else if (calc_phase == kcf_pkg::PH_SECOND) begin
         if (key <= kcf_pkg::KEY_DIGIT_MAX) begin
            rhs_value = rhs_value * VALUE_WIDTH'(10) + VALUE_WIDTH'(key);
         end else if (key == kcf_pkg::KEY_EQUALS) begin
            answer.div_zero = 1'b0;
            case (op_key)
               kcf_pkg::KEY_PLUS:  value = lhs_value + rhs_value;
               kcf_pkg::KEY_MINUS: value = lhs_value - rhs_value;
               kcf_pkg::KEY_TIMES: value = lhs_value * rhs_value;
               kcf_pkg::KEY_DIVIDE: begin
                  if (rhs_value == '0) begin
                     answer.div_zero = 1'b1;
                     value           = '0;
                  end else begin
                     // divide at 64 bits so that min / -1 wraps instead of overflowing
                     dividend = $signed(lhs_value);
                     divisor  = $signed(rhs_value);
                     quotient = dividend / divisor;
                     value    = quotient[VALUE_WIDTH-1:0];
                  end
               end
               default: value = rhs_value;
            endcase
            answer.negative  = value[VALUE_WIDTH-1];
            magnitude        = answer.negative ? -value : value;
            answer.magnitude = RESULT_WIDTH'(magnitude);
            calc_phase       = kcf_pkg::PH_DONE;
            expected_answers.push_back(answer);
         end
      end
   endtask

   always @(posedge clock) begin
      calc_answer_type want;
      if (reset) begin
         clear_calc();
         expected_answers.delete();
         pending_results <= 0;
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            press_key(req_key_code);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected response, magnitude", rsp_result_magnitude, 0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_result_negative !== want.negative)
                  report_mismatch("result_negative", rsp_result_negative, want.negative);
               if (rsp_result_magnitude !== want.magnitude)
                  report_mismatch("result_magnitude", rsp_result_magnitude, want.magnitude);
               if (rsp_divide_by_zero !== want.div_zero)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, want.div_zero);
            end
         end
         pending_results <= expected_answers.size();
      end
   end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Top of the keypad calculator test: drives key requests with random gaps and
// response stalls, and gives the verdict from the checker's mismatch and pending counts.
// Depends on kcf_pkg, keypad_calculator_fsm_core and keypad_calc_checker.
`default_nettype none

module testbench;

   localparam int unsigned VALUE_WIDTH = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned KEY_TARGET  = 450;
   localparam int unsigned KEY_WIDTH   = kcf_pkg::KEY_WIDTH;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [KEY_WIDTH-1:0]             req_key_code = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_result_negative;
   logic [kcf_pkg::RESULT_WIDTH-1:0] rsp_result_magnitude;
   logic                             rsp_divide_by_zero;

   int unsigned pending_results;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;
   int unsigned live_keys = 0;
   int unsigned responses_taken = 0;
   int unsigned hold_left = 0;
   bit          send_idling = 1'b1;
   bit          stall_idling = 1'b1;

   keypad_calculator_fsm_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_negative (rsp_result_negative),
      .rsp_result_magnitude(rsp_result_magnitude),
      .rsp_divide_by_zero  (rsp_divide_by_zero)
   );

   keypad_calc_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_negative (rsp_result_negative),
      .rsp_result_magnitude(rsp_result_magnitude),
      .rsp_divide_by_zero  (rsp_divide_by_zero),
      .pending_results     (pending_results),
      .mismatch_count      (mismatch_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold after the tenth response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_taken <= responses_taken + 1;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rsp_valid && !rsp_stall && responses_taken == 9) begin
            rsp_stall <= 1'b1;
            hold_left <= 300;
         end else begin
            rsp_stall <= stall_idling && ($urandom_range(0, 99) < 30);
         end
      end
   end

   // Offer one key and return at the edge where it is accepted; valid stays high.
   task automatic send_key(input logic [KEY_WIDTH-1:0] key);
      while (send_idling && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      live_keys++;
   endtask

   function automatic int unsigned pick_digit_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)  return 0;
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 5);
      return 6;
   endfunction

   // A key that is none of digit, equals and clear.
   function automatic logic [KEY_WIDTH-1:0] pick_odd_key();
      logic [KEY_WIDTH-1:0] key;
      do begin
         key = KEY_WIDTH'($urandom_range(10, 255));
      end while (key == kcf_pkg::KEY_EQUALS || key == kcf_pkg::KEY_CLEAR);
      return key;
   endfunction

   // Clear, first operand, operator, second operand with stray keys, equals, trailing keys.
   task automatic run_expression();
      logic [KEY_WIDTH-1:0] op_key;
      int unsigned          digits;
      send_key(kcf_pkg::KEY_CLEAR);
      digits = pick_digit_count();
      repeat (digits) send_key(KEY_WIDTH'($urandom_range(0, 9)));
      case ($urandom_range(0, 9))
         0, 1:    op_key = kcf_pkg::KEY_PLUS;
         2, 3:    op_key = kcf_pkg::KEY_MINUS;
         4, 5:    op_key = kcf_pkg::KEY_TIMES;
         6, 7, 8: op_key = kcf_pkg::KEY_DIVIDE;
         default: op_key = pick_odd_key();
      endcase
      send_key(op_key);
      digits = pick_digit_count();
      repeat (digits) begin
         if ($urandom_range(0, 9) == 0) send_key(pick_odd_key());
         send_key(KEY_WIDTH'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) != 0) send_key(kcf_pkg::KEY_EQUALS);
      repeat ($urandom_range(0, 2)) send_key(KEY_WIDTH'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [KEY_WIDTH-1:0] opening_keys[$];
      int unsigned          expr_index;
      opening_keys = '{
         // equals ignored in first operand, then 12 + 3
         kcf_pkg::KEY_EQUALS, 8'd1, 8'd2, kcf_pkg::KEY_PLUS, 8'd3, kcf_pkg::KEY_EQUALS,
         8'd5, kcf_pkg::KEY_CLEAR,
         // most negative value divided by -1
         8'd3, 8'd2, 8'd7, 8'd6, 8'd8, kcf_pkg::KEY_DIVIDE, 8'd6, 8'd5, 8'd5, 8'd3, 8'd5,
         kcf_pkg::KEY_EQUALS, kcf_pkg::KEY_CLEAR,
         // stray operator in second operand, then divide by zero
         8'd7, kcf_pkg::KEY_DIVIDE, kcf_pkg::KEY_TIMES, kcf_pkg::KEY_EQUALS,
         kcf_pkg::KEY_CLEAR,
         // unknown operator yields the second operand
         8'hFF, 8'd9, kcf_pkg::KEY_EQUALS
      };
      expr_index = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_keys[i]) send_key(opening_keys[i]);
      while (live_keys < KEY_TARGET) begin
         send_idling  = !(expr_index >= 30 && expr_index < 45);
         stall_idling = send_idling;
         if (expr_index == 22) begin
            // drain every outstanding response before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 8)) send_key(KEY_WIDTH'($urandom_range(0, 255)));
         end
         run_expression();
         expr_index++;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
